// ===== rtl/bsft_pkg.sv =====
package bsft_pkg;

    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned CFG_IDX_W = 3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FLAG      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ADDRESS   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CTRL_ZERO = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CTRL_ONE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ESCAPE    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_FLAG_SUB  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_ESC_SUB   = 3'd6;

    // Reset values of the configuration registers
    localparam logic [BYTE_W-1:0] RST_FLAG      = 8'd126;
    localparam logic [BYTE_W-1:0] RST_ADDRESS   = 8'd3;
    localparam logic [BYTE_W-1:0] RST_CTRL_ZERO = 8'd0;
    localparam logic [BYTE_W-1:0] RST_CTRL_ONE  = 8'd64;
    localparam logic [BYTE_W-1:0] RST_ESCAPE    = 8'd125;
    localparam logic [BYTE_W-1:0] RST_FLAG_SUB  = 8'd94;
    localparam logic [BYTE_W-1:0] RST_ESC_SUB   = 8'd93;

    typedef struct packed {
        logic [BYTE_W-1:0] payload_byte;
        logic              first_of_frame;
        logic              last_of_frame;
        logic              sequence_bit;
    } t_in_word;

    typedef struct packed {
        logic [BYTE_W-1:0] line_byte;
        logic              run_end;
        logic              frame_end;
    } t_out_word;

    typedef struct packed {
        logic [BYTE_W-1:0] flag_byte;
        logic [BYTE_W-1:0] address_byte;
        logic [BYTE_W-1:0] control_seq_zero;
        logic [BYTE_W-1:0] control_seq_one;
        logic [BYTE_W-1:0] escape_byte;
        logic [BYTE_W-1:0] flag_substitute;
        logic [BYTE_W-1:0] escape_substitute;
    } t_cfg;

    // One classified word handed from front to back
    typedef struct packed {
        logic [BYTE_W-1:0] payload;
        logic [BYTE_W-1:0] check;
        logic              open_hdr;
        logic              last;
        logic              seq;
    } t_job;

    typedef enum logic [3:0] {
        ST_BEGIN,
        ST_FLAG,
        ST_ADDR,
        ST_CTRL,
        ST_HCS,
        ST_DATA,
        ST_DATA_SUB,
        ST_CHECK,
        ST_CHECK_SUB,
        ST_CLOSE
    } t_step;

endpackage

// ===== rtl/bsft_cfg_regs.sv =====
module bsft_cfg_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    input  logic [bsft_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [bsft_pkg::BYTE_W-1:0]    i_cfg_data,
    output logic                          o_cfg_ready,
    output bsft_pkg::t_cfg                o_cfg
);
    import bsft_pkg::*;

    t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.flag_byte         <= RST_FLAG;
            r_cfg.address_byte      <= RST_ADDRESS;
            r_cfg.control_seq_zero  <= RST_CTRL_ZERO;
            r_cfg.control_seq_one   <= RST_CTRL_ONE;
            r_cfg.escape_byte       <= RST_ESCAPE;
            r_cfg.flag_substitute   <= RST_FLAG_SUB;
            r_cfg.escape_substitute <= RST_ESC_SUB;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_FLAG:      r_cfg.flag_byte         <= i_cfg_data;
                CFG_ADDRESS:   r_cfg.address_byte      <= i_cfg_data;
                CFG_CTRL_ZERO: r_cfg.control_seq_zero  <= i_cfg_data;
                CFG_CTRL_ONE:  r_cfg.control_seq_one   <= i_cfg_data;
                CFG_ESCAPE:    r_cfg.escape_byte       <= i_cfg_data;
                CFG_FLAG_SUB:  r_cfg.flag_substitute   <= i_cfg_data;
                CFG_ESC_SUB:   r_cfg.escape_substitute <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

endmodule

// ===== rtl/bsft_front.sv =====
module bsft_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_accept,
    input  bsft_pkg::t_in_word i_word,
    output bsft_pkg::t_job     o_job
);
    import bsft_pkg::*;

    logic              r_inside;
    logic [BYTE_W-1:0] r_check;
    logic              n_inside;
    logic [BYTE_W-1:0] n_check;
    logic              open_hdr;
    logic [BYTE_W-1:0] check_sum;

    // A first mark, or any word while idle, opens a new frame and restarts the check
    always_comb begin
        open_hdr  = i_word.first_of_frame || !r_inside;
        check_sum = (open_hdr ? '0 : r_check) ^ i_word.payload_byte;

        o_job.payload  = i_word.payload_byte;
        o_job.check    = check_sum;
        o_job.open_hdr = open_hdr;
        o_job.last     = i_word.last_of_frame;
        o_job.seq      = i_word.sequence_bit;

        n_inside = !i_word.last_of_frame;
        n_check  = i_word.last_of_frame ? '0 : check_sum;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inside <= 1'b0;
            r_check  <= '0;
        end else if (i_accept) begin
            r_inside <= n_inside;
            r_check  <= n_check;
        end
    end

endmodule

// ===== rtl/bsft_queue.sv =====
module bsft_queue #(
    parameter int unsigned DEPTH = 4
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  bsft_pkg::t_job i_job,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_empty,
    output bsft_pkg::t_job o_head
);
    import bsft_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    t_job             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== rtl/bsft_back.sv =====
module bsft_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  bsft_pkg::t_cfg      i_cfg,
    input  bsft_pkg::t_job      i_job,
    input  logic                i_empty,
    output logic                o_pop,
    output logic                o_out_valid,
    output bsft_pkg::t_out_word o_out_word,
    input  logic                i_out_stall
);
    import bsft_pkg::*;

    t_step             r_step;
    t_step             n_step;
    t_step             cur_step;
    t_step             next_step;
    logic              r_out_valid;
    t_out_word         r_out_word;
    logic              advance;
    logic              fire;
    logic              done;
    logic              frame_end;
    logic [BYTE_W-1:0] line_byte;
    logic [BYTE_W-1:0] ctrl_byte;
    logic              data_is_flag;
    logic              data_is_esc;
    logic              check_is_flag;
    logic              check_is_esc;

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    always_comb begin
        advance   = !r_out_valid || !i_out_stall;
        fire      = advance && !i_empty;
        ctrl_byte = i_job.seq ? i_cfg.control_seq_one : i_cfg.control_seq_zero;

        // flag wins when flag and escape registers are equal
        data_is_flag  = (i_job.payload == i_cfg.flag_byte);
        data_is_esc   = (i_job.payload == i_cfg.escape_byte);
        check_is_flag = (i_job.check == i_cfg.flag_byte);
        check_is_esc  = (i_job.check == i_cfg.escape_byte);

        if (r_step == ST_BEGIN) begin
            cur_step = i_job.open_hdr ? ST_FLAG : ST_DATA;
        end else begin
            cur_step = r_step;
        end

        line_byte = '0;
        done      = 1'b0;
        frame_end = 1'b0;
        next_step = ST_BEGIN;

        case (cur_step)
            ST_FLAG: begin
                line_byte = i_cfg.flag_byte;
                next_step = ST_ADDR;
            end
            ST_ADDR: begin
                line_byte = i_cfg.address_byte;
                next_step = ST_CTRL;
            end
            ST_CTRL: begin
                line_byte = ctrl_byte;
                next_step = ST_HCS;
            end
            ST_HCS: begin
                line_byte = i_cfg.address_byte ^ ctrl_byte;
                next_step = ST_DATA;
            end
            ST_DATA: begin
                if (data_is_flag || data_is_esc) begin
                    line_byte = i_cfg.escape_byte;
                    next_step = ST_DATA_SUB;
                end else begin
                    line_byte = i_job.payload;
                    next_step = ST_CHECK;
                    done      = !i_job.last;
                end
            end
            ST_DATA_SUB: begin
                line_byte = data_is_flag ? i_cfg.flag_substitute : i_cfg.escape_substitute;
                next_step = ST_CHECK;
                done      = !i_job.last;
            end
            ST_CHECK: begin
                if (check_is_flag || check_is_esc) begin
                    line_byte = i_cfg.escape_byte;
                    next_step = ST_CHECK_SUB;
                end else begin
                    line_byte = i_job.check;
                    next_step = ST_CLOSE;
                end
            end
            ST_CHECK_SUB: begin
                line_byte = check_is_flag ? i_cfg.flag_substitute : i_cfg.escape_substitute;
                next_step = ST_CLOSE;
            end
            ST_CLOSE: begin
                line_byte = i_cfg.flag_byte;
                frame_end = 1'b1;
                done      = 1'b1;
            end
            default: begin
                done = 1'b1;
            end
        endcase

        n_step = r_step;
        if (fire) begin
            n_step = done ? ST_BEGIN : next_step;
        end
        o_pop = fire && done;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= ST_BEGIN;
        end else begin
            r_step <= n_step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= !i_empty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out_word.line_byte <= line_byte;
            r_out_word.run_end   <= done;
            r_out_word.frame_end <= frame_end;
        end
    end

endmodule

// ===== rtl/byte_stuffed_frame_transmitter.sv =====
// Channel  | Handshake                  | Payload
// ---------+----------------------------+-------------------------------------
// input    | i_in_valid / o_in_stall    | i_in_data   (payload byte, marks, seq)
// output   | o_out_valid / i_out_stall  | o_out_data  (line byte, run/frame end)
// config   | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
// One line byte leaves per cycle unless the output stalls or the queue is
// empty. The back sequencer emits one byte for a word's payload, four more
// when it opens a frame, one per stuffed byte, two or three for the trailer.
// Reset (synchronous, active low) closes any frame, empties the queue and
// restores the register defaults. A full queue raises o_in_stall; an output
// stall freezes the sequencer while the front keeps filling the queue.
module byte_stuffed_frame_transmitter #(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  bsft_pkg::t_in_word             i_in_data,
    output logic                           o_in_stall,
    output logic                           o_out_valid,
    output bsft_pkg::t_out_word            o_out_data,
    input  logic                           i_out_stall,
    input  logic                           i_cfg_valid,
    input  logic [bsft_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [bsft_pkg::BYTE_W-1:0]    i_cfg_data,
    output logic                           o_cfg_ready
);
    import bsft_pkg::*;

    t_cfg cfg;
    t_job front_job;
    t_job head_job;
    logic in_accept;
    logic q_full;
    logic q_empty;
    logic q_pop;

    // Take a word whenever the queue has room
    assign o_in_stall = q_full;
    assign in_accept  = i_in_valid && !q_full;

    bsft_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready),
        .o_cfg       (cfg)
    );

    // Front: track frame state and the running check, classify each word
    bsft_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (in_accept),
        .i_word   (i_in_data),
        .o_job    (front_job)
    );

    // Decouple front and back
    bsft_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (in_accept),
        .i_job   (front_job),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_head  (head_job)
    );

    // Back: walk header, stuffed payload, trailer one byte per cycle unless stalled
    bsft_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_job       (head_job),
        .i_empty     (q_empty),
        .o_pop       (q_pop),
        .o_out_valid (o_out_valid),
        .o_out_word  (o_out_data),
        .i_out_stall (i_out_stall)
    );

endmodule

// ===== rtl/bsft_checker.sv =====
module bsft_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_in_valid,
    input bsft_pkg::t_in_word             i_in_data,
    input logic                           o_in_stall,
    input logic                           o_out_valid,
    input bsft_pkg::t_out_word            o_out_data,
    input logic                           i_out_stall,
    input logic                           i_cfg_valid,
    input logic [bsft_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input logic [bsft_pkg::BYTE_W-1:0]    i_cfg_data,
    input logic                           o_cfg_ready
);
    import bsft_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("output word dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_out_data))
        else $error("stalled output word changed");

    a_close_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.frame_end |-> o_out_data.run_end)
        else $error("closing flag not last byte of its run");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

endmodule

bind byte_stuffed_frame_transmitter bsft_checker u_bsft_checker (.*);
